FILE: design/iol_pkg.sv
package iol_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int LEN_BITS   = 7;
  localparam int POS_BITS   = 7;
  localparam int OP_BITS    = 3;
  localparam int STAT_BITS  = 2;

  localparam logic [OP_BITS-1:0] OP_READ      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_INS_HEAD  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INS_TAIL  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_INS_AT    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_DELETE    = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [LEN_BITS-1:0]   len_t;

endpackage

FILE: design/iol_ram.sv
module iol_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/indexed_ordered_list_top.sv
// Indexed ordered list of up to CAPACITY values, position 0 being the head.
// A request is transferred when start is high and busy is low; each request
// gives exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. A rejected request (bad position, full list or
// unused code) answers on the cycle after the transfer; busy never rises.
// A read goes through the read-out state, taking the registered memory data.
// An insert or delete holds busy while entries move one place over, read
// and written in turn, and answers in the cycle that busy falls; the pace
// comes from the single entry memory's one write and one registered read port.
// The entry memory is not cleared after reset; entries beyond the length are
// never read, so no clearing pass is needed and requests are taken at once.
module indexed_ordered_list_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [iol_pkg::OP_BITS-1:0]     in_op,
  input  logic [iol_pkg::POS_BITS-1:0]    in_position,
  input  logic [iol_pkg::VALUE_BITS-1:0]  in_value,
  output logic                            out_valid,
  output logic [iol_pkg::VALUE_BITS-1:0]  out_read_value,
  output logic [iol_pkg::STAT_BITS-1:0]   out_status,
  output logic [iol_pkg::LEN_BITS-1:0]    out_length
);
  import iol_pkg::*;

  // Sequencer states. A shift pass alternates between reading the neighbor
  // entry and writing it one place over, then ends in the finish state.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDOUT = 3'd1;
  localparam logic [2:0] S_SRD   = 3'd2;
  localparam logic [2:0] S_SWR   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  len_t       count_r, count_nxt;
  addr_t      idx_r, idx_nxt;
  addr_t      end_r, end_nxt;
  logic       is_ins_r, is_ins_nxt;
  value_t     val_r, val_nxt;

  logic                 out_valid_r, out_valid_nxt;
  value_t               out_rd_r, out_rd_nxt;
  logic [STAT_BITS-1:0] out_st_r, out_st_nxt;
  len_t                 out_len_r, out_len_nxt;

  logic   ram_we;
  addr_t  ram_waddr, ram_raddr;
  value_t ram_wdata, ram_rdata;

  // The shared step unit: one index incrementer/decrementer. Deletes walk
  // toward the tail, inserts toward the head.
  addr_t idx_step;
  assign idx_step = is_ins_r ? idx_r - addr_t'(1) : idx_r + addr_t'(1);

  logic  full;
  logic  pos_lt_count;
  logic  pos_gt_count;
  addr_t pos_addr;
  addr_t count_addr;

  assign full         = (count_r == len_t'(CAPACITY));
  assign pos_lt_count = (len_t'(in_position) < count_r);
  assign pos_gt_count = (len_t'(in_position) > count_r);
  assign pos_addr     = in_position[ADDR_BITS-1:0];
  assign count_addr   = count_r[ADDR_BITS-1:0];

  iol_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    is_ins_nxt    = is_ins_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_rd_nxt    = out_rd_r;
    out_st_nxt    = out_st_r;
    out_len_nxt   = out_len_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = pos_addr;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // Prepare a rejection result; the accepted paths overwrite it.
          out_rd_nxt  = '0;
          out_st_nxt  = ST_RANGE;
          out_len_nxt = count_r;
          val_nxt     = in_value;
          priority if (in_op == OP_READ) begin
            if (pos_lt_count) begin
              state_nxt = S_RDOUT;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else if (in_op == OP_INS_HEAD || in_op == OP_INS_TAIL ||
                       in_op == OP_INS_AT) begin
            is_ins_nxt = 1'b1;
            idx_nxt    = count_addr;
            if (full) begin
              out_st_nxt    = ST_FULL;
              out_valid_nxt = 1'b1;
            end else if (in_op == OP_INS_AT && pos_gt_count) begin
              out_valid_nxt = 1'b1;
            end else begin
              if (in_op == OP_INS_HEAD) begin
                end_nxt = '0;
              end else if (in_op == OP_INS_TAIL) begin
                end_nxt = count_addr;
              end else begin
                end_nxt = pos_addr;
              end
              state_nxt = (count_addr == end_nxt) ? S_FIN : S_SRD;
            end
          end else if (in_op == OP_DELETE) begin
            is_ins_nxt = 1'b0;
            idx_nxt    = pos_addr;
            end_nxt    = addr_t'(count_r - len_t'(1));
            if (pos_lt_count) begin
              state_nxt = (pos_addr == end_nxt) ? S_FIN : S_SRD;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_RDOUT: begin
        out_rd_nxt    = ram_rdata;
        out_st_nxt    = ST_DONE;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SRD: begin
        ram_raddr = idx_step;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_step;
        state_nxt = (idx_step == end_r) ? S_FIN : S_SRD;
      end
      S_FIN: begin
        if (is_ins_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = val_r;
          count_nxt = count_r + len_t'(1);
        end else begin
          count_nxt = count_r - len_t'(1);
        end
        out_rd_nxt    = '0;
        out_st_nxt    = ST_DONE;
        out_len_nxt   = count_nxt;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    end_r     <= end_nxt;
    is_ins_r  <= is_ins_nxt;
    val_r     <= val_nxt;
    out_rd_r  <= out_rd_nxt;
    out_st_r  <= out_st_nxt;
    out_len_r <= out_len_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status     = out_st_r;
  assign out_length     = out_len_r;

endmodule
